>>> hw/rtl/lpfp_pkg.sv
// Shared types and constants for the length-prefixed frame parser.
package lpfp_pkg;

   localparam int unsigned CSR_IDX_BITS = 2;
   localparam int unsigned CSR_DATA_BITS = 16;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MAGIC_VALUE  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TYPE_COUNT   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_BODY_LEN = 2'd2;

   localparam logic [7:0]  MAGIC_RESET        = 8'd0;
   localparam logic [7:0]  TYPE_COUNT_RESET   = 8'd255;
   localparam logic [15:0] MAX_BODY_LEN_RESET = 16'd65535;

   typedef enum logic [3:0] {
      PH_HEAD0 = 4'd0,
      PH_HEAD1 = 4'd1,
      PH_TYPE  = 4'd2,
      PH_LEN0  = 4'd3,
      PH_LEN1  = 4'd4,
      PH_LEN2  = 4'd5,
      PH_LEN3  = 4'd6,
      PH_BODY  = 4'd7,
      PH_CHECK = 4'd8,
      PH_TAIL0 = 4'd9,
      PH_TAIL1 = 4'd10
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_TOO_LONG = 3'd1,
      ST_MAGIC    = 3'd2,
      ST_TYPE     = 3'd3,
      ST_CHECK    = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0]  magic_value;
      logic [7:0]  type_count;
      logic [15:0] max_body_len;
   } cfg_type;

   typedef struct packed {
      logic        frame_end;
      logic [7:0]  body_byte;
      logic [7:0]  msg_type;
      logic [31:0] body_length;
      status_type  status;
   } result_type;

endpackage

>>> hw/rtl/length_prefixed_frame_parser.sv
// Length-prefixed frame parser with XOR checksum, top level.
// An accepted byte's result is registered and shows on rsp_valid in the cycle after it is accepted.
// Throughput: one byte per cycle while no result waits or the waiting result is
// taken in that cycle; only a stalled result holds req_ready low.
// Reset (synchronous): parser returns to the first head magic byte, result
// register empties, csr registers take their defaults.
module length_prefixed_frame_parser #(
   parameter int unsigned LEN_COUNT_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_in_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_frame_end,
   output logic [7:0]                          rsp_body_byte,
   output logic [7:0]                          rsp_msg_type,
   output logic [31:0]                         rsp_body_length,
   output logic [2:0]                          rsp_status,
   input  logic                                csr_write_en,
   input  logic [lpfp_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [lpfp_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import lpfp_pkg::*;

   cfg_type    cfg_ff;
   logic       accept;
   logic       res_valid;
   result_type res;
   result_type rsp_data;
   logic       can_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic_value  <= MAGIC_RESET;
         cfg_ff.type_count   <= TYPE_COUNT_RESET;
         cfg_ff.max_body_len <= MAX_BODY_LEN_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_MAGIC_VALUE:  cfg_ff.magic_value  <= csr_data[7:0];
            CSR_TYPE_COUNT:   cfg_ff.type_count   <= csr_data[7:0];
            CSR_MAX_BODY_LEN: cfg_ff.max_body_len <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_ready = can_load;
   assign accept    = req_valid && can_load;

   lpfp_parse #(
      .LEN_COUNT_BITS(LEN_COUNT_BITS)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   lpfp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (accept && res_valid),
      .load_data (res),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .can_load  (can_load)
   );

   assign rsp_frame_end   = rsp_data.frame_end;
   assign rsp_body_byte   = rsp_data.body_byte;
   assign rsp_msg_type    = rsp_data.msg_type;
   assign rsp_body_length = rsp_data.body_length;
   assign rsp_status      = rsp_data.status;

endmodule

>>> hw/rtl/lpfp_parse.sv
// Frame parser state machine: phase, length, counters and checksum.
module lpfp_parse #(
   parameter int unsigned LEN_COUNT_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          in_byte,
   input  lpfp_pkg::cfg_type   cfg,
   output logic                res_valid,
   output lpfp_pkg::result_type res
);
   import lpfp_pkg::*;

   localparam logic [32:0] CNT_MAX = (33'd1 << LEN_COUNT_BITS) - 33'd1;

   phase_type                 phase_ff, phase_in;
   logic [31:0]               length_ff, length_in;
   logic [LEN_COUNT_BITS-1:0] remaining_ff, remaining_in;
   logic [7:0]                xor_ff, xor_in;
   logic [7:0]                type_ff, type_in;
   logic                      magic_bad_ff, magic_bad_in;
   logic [7:0]                check_ff, check_in;

   logic [31:0]               length_full;
   logic [LEN_COUNT_BITS-1:0] remaining_dec;
   logic                      byte_bad;
   logic                      too_long;

   assign length_full   = {length_ff[23:0], in_byte};
   assign remaining_dec = remaining_ff - LEN_COUNT_BITS'(1);
   assign byte_bad      = (in_byte != cfg.magic_value);
   assign too_long      = (length_full > {16'd0, cfg.max_body_len})
                          || ({1'b0, length_full} > CNT_MAX);

   always_comb begin
      phase_in     = phase_ff;
      length_in    = length_ff;
      remaining_in = remaining_ff;
      xor_in       = xor_ff;
      type_in      = type_ff;
      magic_bad_in = magic_bad_ff;
      check_in     = check_ff;
      res_valid    = 1'b0;
      res          = '{frame_end: 1'b0, body_byte: 8'd0, msg_type: 8'd0,
                       body_length: 32'd0, status: ST_OK};

      case (phase_ff)
         PH_HEAD0: begin
            if (byte_bad) magic_bad_in = 1'b1;
            phase_in = PH_HEAD1;
         end
         PH_HEAD1: begin
            if (byte_bad) magic_bad_in = 1'b1;
            phase_in = PH_TYPE;
         end
         PH_TYPE: begin
            type_in  = in_byte;
            phase_in = PH_LEN0;
         end
         PH_LEN0: begin
            length_in = length_full;
            phase_in  = PH_LEN1;
         end
         PH_LEN1: begin
            length_in = length_full;
            phase_in  = PH_LEN2;
         end
         PH_LEN2: begin
            length_in = length_full;
            phase_in  = PH_LEN3;
         end
         PH_LEN3: begin
            length_in = length_full;
            if (too_long) begin
               // report at once and restart, whatever magic or type
               res_valid       = 1'b1;
               res.frame_end   = 1'b1;
               res.msg_type    = type_ff;
               res.body_length = length_full;
               res.status      = ST_TOO_LONG;
               phase_in        = PH_HEAD0;
               length_in       = 32'd0;
               remaining_in    = '0;
               xor_in          = 8'd0;
               type_in         = 8'd0;
               magic_bad_in    = 1'b0;
               check_in        = 8'd0;
            end else begin
               remaining_in = length_full[LEN_COUNT_BITS-1:0];
               phase_in     = (length_full == 32'd0) ? PH_CHECK : PH_BODY;
            end
         end
         PH_BODY: begin
            xor_in        = xor_ff ^ in_byte;
            remaining_in  = remaining_dec;
            if (remaining_dec == '0) phase_in = PH_CHECK;
            res_valid     = 1'b1;
            res.body_byte = in_byte;
         end
         PH_CHECK: begin
            check_in = in_byte;
            phase_in = PH_TAIL0;
         end
         PH_TAIL0: begin
            if (byte_bad) magic_bad_in = 1'b1;
            phase_in = PH_TAIL1;
         end
         PH_TAIL1: begin
            res_valid       = 1'b1;
            res.frame_end   = 1'b1;
            res.msg_type    = type_ff;
            res.body_length = length_ff;
            if (magic_bad_ff || byte_bad) begin
               res.status = ST_MAGIC;
            end else if (type_ff == 8'd0 || type_ff > cfg.type_count) begin
               res.status = ST_TYPE;
            end else if (xor_ff != check_ff) begin
               res.status = ST_CHECK;
            end else begin
               res.status = ST_OK;
            end
            phase_in     = PH_HEAD0;
            length_in    = 32'd0;
            remaining_in = '0;
            xor_in       = 8'd0;
            type_in      = 8'd0;
            magic_bad_in = 1'b0;
            check_in     = 8'd0;
         end
         default: begin
            phase_in     = PH_HEAD0;
            length_in    = 32'd0;
            remaining_in = '0;
            xor_in       = 8'd0;
            type_in      = 8'd0;
            magic_bad_in = 1'b0;
            check_in     = 8'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEAD0;
         length_ff    <= 32'd0;
         remaining_ff <= '0;
         xor_ff       <= 8'd0;
         type_ff      <= 8'd0;
         magic_bad_ff <= 1'b0;
         check_ff     <= 8'd0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         length_ff    <= length_in;
         remaining_ff <= remaining_in;
         xor_ff       <= xor_in;
         type_ff      <= type_in;
         magic_bad_ff <= magic_bad_in;
         check_ff     <= check_in;
      end
   end

endmodule

>>> hw/rtl/lpfp_out_reg.sv
// Result register between the parser and the response channel.
module lpfp_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  lpfp_pkg::result_type load_data,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output lpfp_pkg::result_type rsp_data,
   output logic                 can_load
);
   import lpfp_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   // a waiting result that is taken this cycle frees the slot
   assign can_load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
